// ----- hdl/rao_pkg.sv -----
// shared constants, register indexes and saturation helpers for the rossler oscillator
// no dependencies
`default_nettype none
package rao_pkg;

    // Q8.24 numbers
    localparam logic [24:0] Q_ONE    = 25'd16777216;
    localparam logic signed [35:0] LIM20   = 36'sd335544320;
    localparam logic signed [35:0] S32_MAX = 36'sd2147483647;
    localparam logic signed [35:0] S32_MIN = -36'sd2147483648;

    // offset that keeps the divide-by-three operand non-negative, multiple of three
    localparam logic [30:0] DIV_OFF   = 31'd1610612736;
    localparam logic [31:0] DIV_OFF_Q = 32'd536870912;

    // register reset values
    localparam logic [24:0] RST_A    = 25'd3355443;
    localparam logic [24:0] RST_B    = 25'd3355443;
    localparam logic [28:0] RST_C    = 29'd95630131;
    localparam logic [28:0] RST_DT   = 29'd287286;
    localparam logic [27:0] RST_GAIN = 28'd0;
    localparam logic [24:0] RST_MIX  = 25'd8388608;
    localparam logic signed [31:0] RST_Y = 32'sd83886080;

    // register indexes
    localparam logic [2:0] REG_A    = 3'd0;
    localparam logic [2:0] REG_B    = 3'd1;
    localparam logic [2:0] REG_C    = 3'd2;
    localparam logic [2:0] REG_DT   = 3'd3;
    localparam logic [2:0] REG_GAIN = 3'd4;
    localparam logic [2:0] REG_MIX  = 3'd5;

    // request to the serial multiplier
    typedef struct packed {
        logic               start;
        logic signed [32:0] opa;
        logic signed [32:0] opb;
    } t_mul_req;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp20(input logic signed [35:0] v);
        logic signed [31:0] r;
        if (v > LIM20) begin
            r = LIM20[31:0];
        end else if (v < -LIM20) begin
            r = 32'(-LIM20);
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/rossler_attractor_oscillator.sv -----
// rossler attractor oscillator: sequencer, state and apb registers
// depends on rao_pkg, rao_mul, rao_div3
`default_nettype none
// usage
//  - input channel: i_in_valid / o_in_stall carry one audio item (i_sample_in, q1.23)
//  - output channel: o_out_valid / i_out_stall carry one mixed item (o_sample_out, q8.24)
//  - every input item gives exactly one output item
//  - each item runs thirteen products on the shared bit-serial multiplier
//    and a serial divide by three before the next item can be accepted
//  - o_in_stall is high from acceptance until the result is written into the
//    output register, so one item is worked on at a time
//  - the output register holds a finished item while the receiver stalls; the
//    next item may already be accepted and worked on, and waits at its end
//    until the output register is free
//  - apb registers (byte address 4*i): a, b, c, dt, gain, mix; write only when idle
//  - reset (synchronous, active low) restores register defaults and the
//    attractor state x=0, y=5.0, z=0, and empties the output register
module rossler_attractor_oscillator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic signed [23:0] i_sample_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_sample_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    // sequencer steps: idle, then one per product or divide
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PERT = 4'd1;   // pert = ext * gain
    localparam logic [3:0] S_KY   = 4'd2;   // a * y
    localparam logic [3:0] S_KZ   = 4'd3;   // z * (x - c)
    localparam logic [3:0] S_Q0   = 4'd4;   // predictor, k * dt
    localparam logic [3:0] S_Q1   = 4'd5;
    localparam logic [3:0] S_Q2   = 4'd6;
    localparam logic [3:0] S_MY   = 4'd7;   // second slope
    localparam logic [3:0] S_MZ   = 4'd8;
    localparam logic [3:0] S_P0   = 4'd9;   // corrector, (k + m) * dt
    localparam logic [3:0] S_P1   = 4'd10;
    localparam logic [3:0] S_P2   = 4'd11;
    localparam logic [3:0] S_DIV  = 4'd12;  // x / 3
    localparam logic [3:0] S_O1   = 4'd13;  // t * (1 - mix)
    localparam logic [3:0] S_O2   = 4'd14;  // mix * ext, then output

    // configuration
    logic [24:0] r_a, r_b, r_mix;
    logic [28:0] r_c, r_dt;
    logic [27:0] r_gain;

    // attractor state and working values
    logic [3:0]         r_state, n_state;
    logic signed [31:0] r_x, r_y, r_z;
    logic signed [24:0] r_ext;
    logic signed [31:0] r_pert, r_k0, r_k1, r_k2, r_qx, r_qy, r_qz;
    logic signed [31:0] r_m0, r_m1, r_m2, r_acc;
    logic               r_ov;
    logic signed [31:0] r_out;

    rao_pkg::t_mul_req  w_req;
    logic               w_mul_done;
    logic signed [31:0] w_res;
    logic               w_div_start, w_div_done;
    logic [30:0]        w_quo;
    logic [30:0]        w_div_num;

    logic               w_in_acc, w_wr;
    logic signed [35:0] w_res36, w_b36, w_c36, w_dt36;
    logic signed [31:0] w_xc, w_qxc, w_t;
    logic signed [25:0] w_omm;
    logic               w_out_free;

    assign pready     = 1'b1;
    assign w_wr       = psel & penable & pwrite;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid & ~o_in_stall;
    assign w_out_free = ~r_ov | ~i_out_stall;

    assign w_res36 = 36'(w_res);
    assign w_b36   = 36'($signed({1'b0, r_b}));
    assign w_c36   = 36'($signed({1'b0, r_c}));
    assign w_dt36  = 36'($signed({1'b0, r_dt}));
    assign w_xc    = rao_pkg::sat32(36'(r_x) - w_c36);
    assign w_qxc   = rao_pkg::sat32(36'(r_qx) - w_c36);
    assign w_omm   = $signed({1'b0, rao_pkg::Q_ONE}) - $signed({1'b0, r_mix});
    // x lies within +-20 so the offset makes it non-negative below 2^31
    assign w_div_num = 31'(r_x) + rao_pkg::DIV_OFF;
    assign w_t       = $signed({1'b0, w_quo} - rao_pkg::DIV_OFF_Q);

    // register reads
    always_comb begin
        unique case (paddr[4:2])
            rao_pkg::REG_A:    prdata = 32'(r_a);
            rao_pkg::REG_B:    prdata = 32'(r_b);
            rao_pkg::REG_C:    prdata = 32'(r_c);
            rao_pkg::REG_DT:   prdata = 32'(r_dt);
            rao_pkg::REG_GAIN: prdata = 32'(r_gain);
            rao_pkg::REG_MIX:  prdata = 32'(r_mix);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= rao_pkg::RST_A;
            r_b    <= rao_pkg::RST_B;
            r_c    <= rao_pkg::RST_C;
            r_dt   <= rao_pkg::RST_DT;
            r_gain <= rao_pkg::RST_GAIN;
            r_mix  <= rao_pkg::RST_MIX;
        end else if (w_wr) begin
            unique case (paddr[4:2])
                rao_pkg::REG_A:    r_a    <= pwdata[24:0];
                rao_pkg::REG_B:    r_b    <= pwdata[24:0];
                rao_pkg::REG_C:    r_c    <= pwdata[28:0];
                rao_pkg::REG_DT:   r_dt   <= pwdata[28:0];
                rao_pkg::REG_GAIN: r_gain <= pwdata[27:0];
                rao_pkg::REG_MIX:  r_mix  <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    // step sequencer and multiplier operand selection
    always_comb begin
        n_state     = r_state;
        w_req.start = 1'b0;
        w_req.opa   = '0;
        w_req.opb   = '0;
        w_div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'($signed({i_sample_in, 1'b0}));
                    w_req.opb   = 33'($signed({1'b0, r_gain}));
                    n_state     = S_PERT;
                end
            end
            S_PERT: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'($signed({1'b0, r_a}));
                    w_req.opb   = 33'(r_y);
                    n_state     = S_KY;
                end
            end
            S_KY: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(r_z);
                    w_req.opb   = 33'(w_xc);
                    n_state     = S_KZ;
                end
            end
            S_KZ: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(r_k0);
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_Q0;
                end
            end
            S_Q0: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(r_k1);
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_Q1;
                end
            end
            S_Q1: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(r_k2);
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_Q2;
                end
            end
            S_Q2: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'($signed({1'b0, r_a}));
                    w_req.opb   = 33'(r_qy);
                    n_state     = S_MY;
                end
            end
            S_MY: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(r_qz);
                    w_req.opb   = 33'(w_qxc);
                    n_state     = S_MZ;
                end
            end
            S_MZ: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(rao_pkg::sat32(36'(r_k0) + 36'(r_m0)));
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_P0;
                end
            end
            S_P0: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(rao_pkg::sat32(36'(r_k1) + 36'(r_m1)));
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_P1;
                end
            end
            S_P1: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(rao_pkg::sat32(36'(r_k2) + 36'(r_m2)));
                    w_req.opb   = 33'(w_dt36);
                    n_state     = S_P2;
                end
            end
            S_P2: begin
                if (w_mul_done) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'(w_t);
                    w_req.opb   = 33'(w_omm);
                    n_state     = S_O1;
                end
            end
            S_O1: begin
                if (w_mul_done) begin
                    w_req.start = 1'b1;
                    w_req.opa   = 33'($signed({1'b0, r_mix}));
                    w_req.opb   = 33'(r_ext);
                    n_state     = S_O2;
                end
            end
            S_O2: begin
                // hold here while the previous item still waits at the output
                if (w_mul_done && w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_x     <= '0;
            r_y     <= rao_pkg::RST_Y;
            r_z     <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_O2 && w_mul_done && w_out_free) begin
                r_ov <= 1'b1;
            end else if (~i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (w_mul_done) begin
                if (r_state == S_P0) r_x <= rao_pkg::clamp20(36'(r_x) + w_res36);
                if (r_state == S_P1) r_y <= rao_pkg::clamp20(36'(r_y) + w_res36);
                if (r_state == S_P2) r_z <= rao_pkg::clamp20(36'(r_z) + w_res36);
            end
        end
    end

    // working registers, written at acceptance and as each product completes
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ext <= $signed({i_sample_in, 1'b0});
        end
        if (w_mul_done) begin
            case (r_state)
                S_PERT: begin
                    r_pert <= w_res;
                    r_k0   <= rao_pkg::sat32(-36'(r_y) - 36'(r_z));
                end
                S_KY: r_k1 <= rao_pkg::sat32(36'(r_x) + w_res36 + 36'(r_pert));
                S_KZ: r_k2 <= rao_pkg::sat32(w_b36 + w_res36);
                S_Q0: r_qx <= rao_pkg::sat32(36'(r_x) + w_res36);
                S_Q1: r_qy <= rao_pkg::sat32(36'(r_y) + w_res36);
                S_Q2: r_qz <= rao_pkg::sat32(36'(r_z) + w_res36);
                S_MY: begin
                    r_m1 <= rao_pkg::sat32(36'(r_qx) + w_res36 + 36'(r_pert));
                    r_m0 <= rao_pkg::sat32(-36'(r_qy) - 36'(r_qz));
                end
                S_MZ: r_m2  <= rao_pkg::sat32(w_b36 + w_res36);
                S_O1: r_acc <= w_res;
                S_O2: begin
                    if (w_out_free) begin
                        r_out <= rao_pkg::sat32(36'(r_acc) + w_res36);
                    end
                end
                default: ;
            endcase
        end
    end

    rao_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_done  (w_mul_done),
        .o_res   (w_res)
    );

    rao_div3 u_div3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    assign o_out_valid  = r_ov;
    assign o_sample_out = r_out;
endmodule
`default_nettype wire

// ----- hdl/rao_mul.sv -----
// bit-serial signed multiplier, one multiplier bit a cycle, floored q8.24 result
// depends on rao_pkg
`default_nettype none
module rao_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire rao_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic signed [31:0]     o_res
);
    logic signed [32:0] r_a;
    logic signed [34:0] r_hi;
    logic        [32:0] r_lo;
    logic        [5:0]  r_cnt;
    logic               r_done;

    logic signed [34:0] w_add;
    logic signed [34:0] w_sum;
    logic signed [67:0] w_full;

    always_comb begin
        // top multiplier bit carries negative weight
        if (!r_lo[0]) begin
            w_add = '0;
        end else if (r_cnt == 6'd1) begin
            w_add = -35'(r_a);
        end else begin
            w_add = 35'(r_a);
        end
        w_sum  = r_hi + w_add;
        w_full = {r_hi, r_lo};
        o_res  = rao_pkg::sat32(w_full[59:24]);
        if (w_full[67:59] != {9{w_full[67]}}) begin
            o_res = w_full[67] ? 32'sh80000000 : 32'sh7fffffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= 6'd33;
            r_done <= 1'b0;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.opa;
            r_hi <= '0;
            r_lo <= i_req.opb;
        end else if (r_cnt != 6'd0) begin
            r_hi <= {w_sum[34], w_sum[34:1]};
            r_lo <= {w_sum[0], r_lo[32:1]};
        end
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

// ----- hdl/rao_div3.sv -----
// bit-serial restoring divide by three of a 31-bit unsigned value
// no package dependencies
`default_nettype none
module rao_div3 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [30:0] i_num,
    output logic             o_done,
    output logic [30:0]      o_quo
);
    logic [30:0] r_num;
    logic [1:0]  r_rem;
    logic [4:0]  r_cnt;
    logic        r_done;
    logic [2:0]  w_tr;

    assign w_tr = {r_rem, r_num[30]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= 5'd31;
            r_done <= 1'b0;
        end else if (r_cnt != 5'd0) begin
            r_cnt <= r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
        end else if (r_cnt != 5'd0) begin
            if (w_tr >= 3'd3) begin
                r_rem <= 2'(w_tr - 3'd3);
                r_num <= {r_num[29:0], 1'b1};
            end else begin
                r_rem <= w_tr[1:0];
                r_num <= {r_num[29:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// testbench for the rossler attractor oscillator: directed table then random audio items
// depends on rao_pkg and rossler_attractor_oscillator; checks each item against a local predictor
module tb;

    // number bounds of the q8.24 arithmetic
    localparam longint QONE = 64'sd16777216;
    localparam longint LIMIT20 = 64'sd335544320;
    localparam longint MAXS = 64'sd2147483647;
    localparam longint MINS = -64'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [23:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] sample_out;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    rossler_attractor_oscillator dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_sample_in(sample_in),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_sample_out(sample_out),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // local copy of the coefficients and the attractor state
    longint coef_a, coef_b, coef_c, dt, gain, mix;
    longint px, py, pz;
    logic signed [31:0] mixed_q[$];
    int mismatches = 0;
    int idle_pct = 35;

    function automatic longint sat(longint v);
        if (v > MAXS) return MAXS;
        if (v < MINS) return MINS;
        return v;
    endfunction

    function automatic longint lim20(longint v);
        if (v > LIMIT20) return LIMIT20;
        if (v < -LIMIT20) return -LIMIT20;
        return v;
    endfunction

    // q8.24 product floored, then saturated (>>> floors)
    function automatic longint qmul(longint a, longint b);
        return sat((a * b) >>> 24);
    endfunction

    function automatic void slope_eval(longint x, longint y, longint z, longint pert,
                                       output longint d0, output longint d1,
                                       output longint d2);
        d0 = sat(-y - z);
        d1 = sat(x + qmul(coef_a, y) + pert);
        d2 = sat(coef_b + qmul(z, sat(x - coef_c)));
    endfunction

    // one heun step, returns the mixed output
    function automatic logic signed [31:0] heun_mix(logic signed [23:0] s);
        longint ext, pert, k0, k1, k2, m0, m1, m2, t;
        ext = longint'(s) * 2;
        pert = qmul(ext, gain);
        slope_eval(px, py, pz, pert, k0, k1, k2);
        slope_eval(sat(px + qmul(k0, dt)), sat(py + qmul(k1, dt)),
                   sat(pz + qmul(k2, dt)), pert, m0, m1, m2);
        px = lim20(px + qmul(sat(k0 + m0), dt));
        py = lim20(py + qmul(sat(k1 + m1), dt));
        pz = lim20(pz + qmul(sat(k2 + m2), dt));
        t = (px >= 0) ? px / 3 : -((-px + 2) / 3);
        return 32'(sat(qmul(t, QONE - mix) + qmul(mix, ext)));
    endfunction

    // apb write, then the register is read back at the same address
    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] want;
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (idx)
            rao_pkg::REG_A:    begin want = val & 32'h1FFFFFF;  coef_a = want; end
            rao_pkg::REG_B:    begin want = val & 32'h1FFFFFF;  coef_b = want; end
            rao_pkg::REG_C:    begin want = val & 32'h1FFFFFFF; coef_c = want; end
            rao_pkg::REG_DT:   begin want = val & 32'h1FFFFFFF; dt     = want; end
            rao_pkg::REG_GAIN: begin want = val & 32'hFFFFFFF;  gain   = want; end
            rao_pkg::REG_MIX:  begin want = val & 32'h1FFFFFF;  mix    = want; end
            default: want = '0;
        endcase
        if (prdata !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("prdata expected %0d got %0d", want, prdata);
        end
    endtask

    // send one item, predicted output queued at acceptance
    task automatic send_item(logic signed [23:0] s, bit may_idle);
        @(negedge clk);
        while (may_idle && $urandom_range(99) < idle_pct) @(negedge clk);
        in_valid = 1'b1;
        sample_in = s;
        do @(posedge clk); while (in_stall);
        mixed_q.push_back(heun_mix(s));
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain;
        while (mixed_q.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
    endtask

    function automatic logic signed [23:0] rand_sample();
        case ($urandom_range(7))
            0: return 24'sh7FFFFF;
            1: return -24'sh800000;
            default: return 24'($urandom());
        endcase
    endfunction

    // receiver stall, changes at the falling edge
    always @(negedge clk) out_stall <= rst_n && ($urandom_range(99) < idle_pct);

    // output checker
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (mixed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected item %0d", sample_out);
            end else begin
                logic signed [31:0] want;
                want = mixed_q.pop_front();
                if (want !== sample_out) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("sample_out expected %0d got %0d", want, sample_out);
                end
            end
        end
    end

    // directed rows: sample only, every row goes through the predictor
    typedef struct {
        logic signed [23:0] s;
    } t_row;
    t_row rows[12] = '{
        '{24'sd0}, '{24'sh7FFFFF}, '{-24'sh800000}, '{24'sd1}, '{-24'sd1},
        '{24'sh400000}, '{-24'sh400000}, '{24'sh555555}, '{24'shAAAAAA},
        '{24'sh0F0F0F}, '{24'sh7FFFFF}, '{-24'sh800000}
    };

    initial begin
        coef_a = rao_pkg::RST_A; coef_b = rao_pkg::RST_B; coef_c = rao_pkg::RST_C;
        dt = rao_pkg::RST_DT; gain = rao_pkg::RST_GAIN; mix = rao_pkg::RST_MIX;
        px = 0; py = rao_pkg::RST_Y; pz = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        // first row after reset: x stays at zero in the first step only if slopes cancel,
        // so every row goes through the predictor
        foreach (rows[i]) send_item(rows[i].s, 1'b1);
        drain();
        // extremes of every register
        reg_write(rao_pkg::REG_A, 32'hFFFFFFFF);
        reg_write(rao_pkg::REG_B, 32'h1FFFFFF);
        reg_write(rao_pkg::REG_C, 32'h1FFFFFFF);
        reg_write(rao_pkg::REG_DT, 32'h1FFFFFFF);
        reg_write(rao_pkg::REG_GAIN, 32'hFFFFFFF);
        reg_write(rao_pkg::REG_MIX, 32'h1FFFFFF);
        repeat (8) send_item(rand_sample(), 1'b1);
        drain();
        reg_write(rao_pkg::REG_A, 0); reg_write(rao_pkg::REG_B, 0);
        reg_write(rao_pkg::REG_C, 0); reg_write(rao_pkg::REG_DT, 0);
        reg_write(rao_pkg::REG_GAIN, 0); reg_write(rao_pkg::REG_MIX, 0);
        repeat (5) send_item(rand_sample(), 1'b1);
        drain();
        // random phases with random settings, one phase without idling
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(rao_pkg::REG_A, $urandom_range(16777216));
            reg_write(rao_pkg::REG_B, $urandom_range(16777216));
            reg_write(rao_pkg::REG_C, $urandom_range(503316480));
            reg_write(rao_pkg::REG_DT,
                      (ph % 3 == 0) ? $urandom() : $urandom_range(2000000));
            reg_write(rao_pkg::REG_GAIN, $urandom_range(167772160));
            reg_write(rao_pkg::REG_MIX,
                      (ph == 5) ? $urandom() : $urandom_range(16777216));
            idle_pct = (ph == 3) ? 0 : 35;
            for (int n = 0; n < 160; n++) send_item(rand_sample(), 1'b1);
            drain();
        end
        idle_pct = 35;
        drain();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard limit: about 1300 items, several times over
    initial begin
        #50000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
